### design/block_buffer_cache_lru_defines.svh
// assertion macros shared by the block buffer cache modules
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

// same-cycle implication, checked on every rising clock outside reset
`define BBC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bbc_pkg.sv
// shared constants, payload structs and control types for the block buffer cache
package bbc_pkg;

   localparam int NUM_BUFFERS = 32;
   localparam int IDX_W       = $clog2(NUM_BUFFERS);
   localparam int DEV_W       = 8;
   localparam int BLK_W       = 32;
   localparam int CNT_W       = 8;
   localparam int BIDX_W      = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [1:0] CMD_GET     = 2'd0;
   localparam logic [1:0] CMD_DIRTY   = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_FREE  = 2'd1;
   localparam logic [1:0] STAT_UNREF    = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block_number;
      logic [BIDX_W-1:0] buffer_index;
   } req_type;

   typedef struct packed {
      logic [BIDX_W-1:0] result_index;
      logic [1:0]        status;
      logic              cache_hit;
      logic              fetch_needed;
      logic              writeback_needed;
      logic [DEV_W-1:0]  out_device;
      logic [BLK_W-1:0]  out_block_number;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_LOOKUP,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic lookup;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_is_get;
      logic scan_last;
      logic slot_free;
   } ctrl_sts_type;

endpackage

### design/bbc_ctrl.sv
// sequencing state machine: accept, tag scan or single lookup, update and result
`include "block_buffer_cache_lru_defines.svh"

module bbc_ctrl
   import bbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = sts.in_is_get ? S_SCAN : S_LOOKUP;
            end
         end
         S_SCAN: begin
            if (sts.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_APPLY;
         end
         S_LOOKUP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (sts.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         S_SCAN_END: begin
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         S_APPLY: begin
            cmd.apply = sts.slot_free;
         end
         default: begin
         end
      endcase
   end

   `BBC_ASSERT_IMP(a_scan_end_from_scan, state_ff == S_SCAN_END, $past(state_ff) == S_SCAN, "scan end not preceded by scan")
   `BBC_ASSERT_NXT(a_accept_leaves_idle, cmd.load_req, state_ff != S_IDLE, "accepted item did not start work")

endmodule

### design/bbc_dp.sv
// datapath: tag memory, per-buffer counts and flags, recency order, scan and result register
`include "block_buffer_cache_lru_defines.svh"

module bbc_dp
   import bbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output ctrl_sts_type sts,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   // request held for the whole item
   req_type req_ff;

   // tag memory, unwritten entries read as zero
   logic [DEV_W-1:0] tag_dev_ff [NUM_BUFFERS];
   logic [BLK_W-1:0] tag_blk_ff [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] tag_wr_ff;

   // per-buffer state
   logic [CNT_W-1:0] cnt_ff [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] valid_ff;
   logic [NUM_BUFFERS-1:0] dirty_ff;
   logic [IDX_W-1:0] pos_ff [NUM_BUFFERS];

   // registered read port
   logic             rd_pend_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [DEV_W-1:0] rd_dev_ff;
   logic [BLK_W-1:0] rd_blk_ff;
   logic             rd_written_ff;
   logic [CNT_W-1:0] rd_cnt_ff;
   logic [IDX_W-1:0] rd_pos_ff;
   logic             rd_dirty_ff;
   logic             rd_valid_ff;

   logic [IDX_W-1:0] scan_cnt_ff;
   logic [IDX_W-1:0] scan_cnt_in;

   // best hit (most recent match) and best victim (least recent free)
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic [IDX_W-1:0] found_pos_ff, found_pos_in;
   logic [CNT_W-1:0] found_cnt_ff, found_cnt_in;
   logic             found_valid_ff, found_valid_in;
   logic             vic_ff, vic_in;
   logic [IDX_W-1:0] vic_idx_ff, vic_idx_in;
   logic [IDX_W-1:0] vic_pos_ff, vic_pos_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] req_addr;
   logic [DEV_W-1:0] rd_dev;
   logic [BLK_W-1:0] rd_blk;
   logic             tag_match;
   logic             in_range;

   rsp_type          res;
   logic [IDX_W-1:0] wr_addr;
   logic             tag_we;
   logic             cnt_we;
   logic             valid_we;
   logic             dirty_we;
   logic             touch;
   logic [CNT_W-1:0] ent_cnt_in;
   logic             ent_valid_in;
   logic             ent_dirty_in;

   assign req_addr = IDX_W'(req_ff.buffer_index);
   assign in_range = 32'(req_ff.buffer_index) < 32'(NUM_BUFFERS);
   assign rd_en    = cmd.scan_step | cmd.lookup;
   assign rd_addr  = cmd.scan_step ? scan_cnt_ff : req_addr;
   assign rd_dev   = rd_written_ff ? rd_dev_ff : '0;
   assign rd_blk   = rd_written_ff ? rd_blk_ff : '0;
   assign tag_match = (rd_dev == req_ff.device) && (rd_blk == req_ff.block_number);

   assign sts.in_is_get = req_data.command == CMD_GET;
   assign sts.scan_last = scan_cnt_ff == IDX_W'(NUM_BUFFERS - 1);
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff     <= rd_addr;
         rd_dev_ff     <= tag_dev_ff[rd_addr];
         rd_blk_ff     <= tag_blk_ff[rd_addr];
         rd_written_ff <= tag_wr_ff[rd_addr];
         rd_cnt_ff     <= cnt_ff[rd_addr];
         rd_pos_ff     <= pos_ff[rd_addr];
         rd_dirty_ff   <= dirty_ff[rd_addr];
         rd_valid_ff   <= valid_ff[rd_addr];
      end
   end

   // tag memory write, victim retag only
   always_ff @(posedge clock) begin
      if (cmd.apply && tag_we) begin
         tag_dev_ff[wr_addr] <= req_ff.device;
         tag_blk_ff[wr_addr] <= req_ff.block_number;
      end
   end

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (cmd.load_req) begin
         scan_cnt_in = '0;
      end else if (cmd.scan_step) begin
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_pos_in   = found_pos_ff;
      found_cnt_in   = found_cnt_ff;
      found_valid_in = found_valid_ff;
      vic_in         = vic_ff;
      vic_idx_in     = vic_idx_ff;
      vic_pos_in     = vic_pos_ff;
      if (cmd.load_req) begin
         found_in = 1'b0;
         vic_in   = 1'b0;
      end else if (rd_pend_ff) begin
         if (tag_match && (!found_ff || rd_pos_ff < found_pos_ff)) begin
            found_in       = 1'b1;
            found_idx_in   = rd_idx_ff;
            found_pos_in   = rd_pos_ff;
            found_cnt_in   = rd_cnt_ff;
            found_valid_in = rd_valid_ff;
         end
         if (rd_cnt_ff == '0 && (!vic_ff || rd_pos_ff > vic_pos_ff)) begin
            vic_in     = 1'b1;
            vic_idx_in = rd_idx_ff;
            vic_pos_in = rd_pos_ff;
         end
      end
   end

   // result and state update of the item
   always_comb begin
      res          = '0;
      res.result_index = req_ff.buffer_index;
      wr_addr      = req_addr;
      tag_we       = 1'b0;
      cnt_we       = 1'b0;
      valid_we     = 1'b0;
      dirty_we     = 1'b0;
      touch        = 1'b0;
      ent_cnt_in   = '0;
      ent_valid_in = 1'b0;
      ent_dirty_in = 1'b0;
      case (req_ff.command)
         CMD_GET: begin
            res.result_index = '0;
            if (found_ff) begin
               wr_addr              = found_idx_ff;
               res.result_index     = BIDX_W'(found_idx_ff);
               res.cache_hit        = 1'b1;
               res.out_device       = req_ff.device;
               res.out_block_number = req_ff.block_number;
               if (found_cnt_ff == CNT_MAX) begin
                  res.status = STAT_OVERFLOW;
               end else begin
                  cnt_we     = 1'b1;
                  ent_cnt_in = found_cnt_ff + 1'b1;
                  if (!found_valid_ff) begin
                     res.fetch_needed = 1'b1;
                     valid_we         = 1'b1;
                     ent_valid_in     = 1'b1;
                     dirty_we         = 1'b1;
                  end
               end
            end else if (vic_ff) begin
               wr_addr              = vic_idx_ff;
               res.result_index     = BIDX_W'(vic_idx_ff);
               res.fetch_needed     = 1'b1;
               res.out_device       = req_ff.device;
               res.out_block_number = req_ff.block_number;
               tag_we               = 1'b1;
               cnt_we               = 1'b1;
               ent_cnt_in           = CNT_W'(1);
               valid_we             = 1'b1;
               ent_valid_in         = 1'b1;
               dirty_we             = 1'b1;
            end else begin
               res.status = STAT_NO_FREE;
            end
         end
         CMD_DIRTY: begin
            if (in_range) begin
               dirty_we             = 1'b1;
               ent_dirty_in         = 1'b1;
               res.out_device       = rd_dev;
               res.out_block_number = rd_blk;
            end
         end
         CMD_RELEASE: begin
            if (!in_range) begin
               res.status = STAT_UNREF;
            end else begin
               res.out_device       = rd_dev;
               res.out_block_number = rd_blk;
               if (rd_cnt_ff == '0) begin
                  res.status = STAT_UNREF;
               end else begin
                  if (rd_dirty_ff) begin
                     res.writeback_needed = 1'b1;
                     dirty_we             = 1'b1;
                  end
                  cnt_we     = 1'b1;
                  ent_cnt_in = rd_cnt_ff - 1'b1;
                  // last reference gone: buffer becomes most recent
                  touch      = rd_cnt_ff == CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_wr_ff <= '0;
         valid_ff  <= '0;
         dirty_ff  <= '0;
         cnt_ff    <= '{default: '0};
      end else if (cmd.apply) begin
         if (tag_we) begin
            tag_wr_ff[wr_addr] <= 1'b1;
         end
         if (cnt_we) begin
            cnt_ff[wr_addr] <= ent_cnt_in;
         end
         if (valid_we) begin
            valid_ff[wr_addr] <= ent_valid_in;
         end
         if (dirty_we) begin
            dirty_ff[wr_addr] <= ent_dirty_in;
         end
      end
   end

   // recency order, position zero is most recent
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            pos_ff[i] <= IDX_W'(NUM_BUFFERS - 1 - i);
         end
      end else if (cmd.apply && touch) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (IDX_W'(i) == wr_addr) begin
               pos_ff[i] <= '0;
            end else if (pos_ff[i] < rd_pos_ff) begin
               pos_ff[i] <= pos_ff[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         scan_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         vic_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= cmd.scan_step;
         scan_cnt_ff  <= scan_cnt_in;
         found_ff     <= found_in;
         vic_ff       <= vic_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff   <= found_idx_in;
      found_pos_ff   <= found_pos_in;
      found_cnt_ff   <= found_cnt_in;
      found_valid_ff <= found_valid_in;
      vic_idx_ff     <= vic_idx_in;
      vic_pos_ff     <= vic_pos_in;
      if (cmd.apply) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BBC_ASSERT_IMP(a_apply_slot_free, cmd.apply, !rsp_valid_ff || !rsp_stall, "held item overwritten")
   `BBC_ASSERT_IMP(a_victim_unreferenced, cmd.apply && req_ff.command == CMD_GET && !found_ff && vic_ff, cnt_ff[vic_idx_ff] == '0, "victim buffer is referenced")
   `BBC_ASSERT_NXT(a_apply_gives_item, cmd.apply, rsp_valid, "update did not produce an item")

endmodule

### design/block_buffer_cache_lru.sv
// top level of the lru block buffer cache tag and policy engine
//
//   port group  dir  handshake           payload
//   req_        in   req_valid/req_stall  req_type: command, device, block, index
//   rsp_        out  rsp_valid/rsp_stall  rsp_type: index, status, flags, tags
//
// a get reads the tags of all 32 buffers in turn, as set by the single read
// port of the tag memory, then drains the scan and applies the update before
// the next item is taken.
// mark dirty, release and the unused command take one lookup, then the update.
// synchronous active-high reset; no clearing pass, tags read as zero until written.
// a new item is accepted while the previous result waits under rsp_stall;
// its update waits until the result register is free.

module block_buffer_cache_lru
   import bbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   bbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
